// ===== rtl/core/m2pm_pkg.sv =====
package m2pm_pkg;
	localparam int unsigned ElemWidth = 32;
	localparam int unsigned CntWidth  = $clog2(ElemWidth + 1);

	typedef logic [ElemWidth-1:0] elem_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_LOAD,
		ST_RED_RUN,
		ST_EXP_CHECK,
		ST_MM_LOAD,
		ST_MM_RUN,
		ST_MM_SUM,
		ST_MM_NEXT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MM_ACC_BASE,
		MM_BASE_BASE
	} mm_kind_t;

	// Modular add for x, y < m, with a carry-safe compare.
	function automatic elem_t add_mod(input elem_t x, input elem_t y, input elem_t m);
		logic [ElemWidth:0] s;
		logic [ElemWidth:0] d;
		begin
			s = {1'b0, x} + {1'b0, y};
			d = s - {1'b0, m};
			add_mod = (s >= {1'b0, m}) ? d[ElemWidth-1:0] : s[ElemWidth-1:0];
		end
	endfunction
endpackage

// ===== rtl/core/matrix2x2_power_mod_unit.sv =====
// Channel   | Ports                                         | Handshake
// input     | matrix_a00..a11, exponent, modulus            | start & !busy
// result    | result_r00..r11, status                       | done strobe, 1 cycle
// One transaction at a time; busy stays high through the done strobe.
// Steps: reduce the four base entries mod m, then per exponent bit up to two 2x2 products,
// each 8 bit-serial modular multiplies with a modular sum per entry; the bit-serial
// add-double loop of the multiplier sets the run time.
// Modulus zero: the accepted transaction goes straight to ST_DONE, and done is registered from that state.
// Reset clears all control state; the receiver cannot stall.
module matrix2x2_power_mod_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  m2pm_pkg::elem_t matrix_a00,
	input  m2pm_pkg::elem_t matrix_a01,
	input  m2pm_pkg::elem_t matrix_a10,
	input  m2pm_pkg::elem_t matrix_a11,
	input  m2pm_pkg::elem_t exponent,
	input  m2pm_pkg::elem_t modulus,
	output logic           done,
	output m2pm_pkg::elem_t result_r00,
	output m2pm_pkg::elem_t result_r01,
	output m2pm_pkg::elem_t result_r10,
	output m2pm_pkg::elem_t result_r11,
	output logic           status
);
	import m2pm_pkg::*;

	state_t   state_q, state_d;
	elem_t    acc_q [4];
	elem_t    base_q [4];
	elem_t    new_q [4];
	elem_t    ex_q, m_q;
	elem_t    part_q;
	logic [1:0] idx_q;
	logic     half_q;
	mm_kind_t kind_q;
	logic     err_q;
	logic     done_q;
	logic     accept;

	logic  red_load, red_done, mm_load, mm_done;
	elem_t red_rem, mm_prod, mx, my;

	assign accept = start && !busy;

	m2pm_reduce u_red (
		.clk(clk), .arst_n(arst_n), .load(red_load), .a(base_q[idx_q]),
		.m(m_q), .done(red_done), .rem(red_rem)
	);

	m2pm_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .load(mm_load), .x(mx), .y(my),
		.m(m_q), .done(mm_done), .prod(mm_prod)
	);

	// Entry idx = {row, col}; term half picks p[row][half] * q[half][col].
	always_comb begin
		mx = (kind_q == MM_ACC_BASE) ? acc_q[{idx_q[1], half_q}] : base_q[{idx_q[1], half_q}];
		my = base_q[{half_q, idx_q[0]}];
	end

	always_comb begin
		state_d  = state_q;
		red_load = 1'b0;
		mm_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = (modulus == '0) ? ST_DONE : ST_RED_LOAD;
			ST_RED_LOAD: begin
				red_load = 1'b1;
				state_d  = ST_RED_RUN;
			end
			ST_RED_RUN:   if (red_done) state_d = (idx_q == 2'd3) ? ST_EXP_CHECK : ST_RED_LOAD;
			ST_EXP_CHECK: state_d = (ex_q == '0) ? ST_DONE : ST_MM_LOAD;
			ST_MM_LOAD: begin
				mm_load = 1'b1;
				state_d = ST_MM_RUN;
			end
			ST_MM_RUN:    if (mm_done) state_d = half_q ? ST_MM_SUM : ST_MM_LOAD;
			ST_MM_SUM:    state_d = (idx_q == 2'd3) ? ST_MM_NEXT : ST_MM_LOAD;
			ST_MM_NEXT:   state_d = ST_MM_LOAD;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
		if (state_q == ST_MM_NEXT) begin
			if (kind_q == MM_ACC_BASE) begin
				state_d = ((ex_q >> 1) != '0) ? ST_MM_LOAD : ST_DONE;
			end else begin
				state_d = ST_EXP_CHECK;
			end
		end
		if (state_q == ST_EXP_CHECK && ex_q != '0 && !ex_q[0]) begin
			state_d = ((ex_q >> 1) != '0) ? ST_MM_LOAD : ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			idx_q   <= '0;
			half_q  <= 1'b0;
			kind_q  <= MM_ACC_BASE;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
			unique case (state_q)
				ST_IDLE: if (accept) begin
					idx_q  <= '0;
					half_q <= 1'b0;
					err_q  <= (modulus == '0);
				end
				ST_RED_RUN: if (red_done) idx_q <= idx_q + 1'b1;
				ST_EXP_CHECK: begin
					idx_q  <= '0;
					half_q <= 1'b0;
					kind_q <= ex_q[0] ? MM_ACC_BASE : MM_BASE_BASE;
				end
				ST_MM_RUN: if (mm_done) half_q <= ~half_q;
				ST_MM_SUM: idx_q <= idx_q + 1'b1;
				ST_MM_NEXT: begin
					idx_q  <= '0;
					half_q <= 1'b0;
					kind_q <= MM_BASE_BASE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) begin
				base_q[0] <= matrix_a00;
				base_q[1] <= matrix_a01;
				base_q[2] <= matrix_a10;
				base_q[3] <= matrix_a11;
				acc_q[0]  <= elem_t'(1);
				acc_q[1]  <= '0;
				acc_q[2]  <= '0;
				acc_q[3]  <= elem_t'(1);
				ex_q      <= exponent;
				m_q       <= modulus;
			end
			ST_RED_RUN: if (red_done) base_q[idx_q] <= red_rem;
			ST_MM_RUN: if (mm_done && !half_q) part_q <= mm_prod;
			ST_MM_SUM: new_q[idx_q] <= add_mod(part_q, mm_prod, m_q);
			ST_MM_NEXT: begin
				if (kind_q == MM_ACC_BASE) begin
					acc_q <= new_q;
					if ((ex_q >> 1) == '0) ex_q <= '0;
				end else begin
					base_q <= new_q;
					ex_q   <= ex_q >> 1;
				end
			end
			ST_EXP_CHECK: if (ex_q != '0 && !ex_q[0] && (ex_q >> 1) == '0) ex_q <= '0;
			default: ;
		endcase
	end

	assign busy       = (state_q != ST_IDLE) || done_q;
	assign done       = done_q;
	assign status     = err_q;
	assign result_r00 = err_q ? '0 : acc_q[0];
	assign result_r01 = err_q ? '0 : acc_q[1];
	assign result_r10 = err_q ? '0 : acc_q[2];
	assign result_r11 = err_q ? '0 : acc_q[3];

	a_done_after_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DONE) else $error("done without finish");
	a_busy_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("idle at done");
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && !done_q) |=> state_q != ST_IDLE)
		else $error("start dropped");
endmodule

// ===== rtl/core/m2pm_mulmod.sv =====
module m2pm_mulmod (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  m2pm_pkg::elem_t x,
	input  m2pm_pkg::elem_t y,
	input  m2pm_pkg::elem_t m,
	output logic           done,
	output m2pm_pkg::elem_t prod
);
	import m2pm_pkg::*;

	elem_t x_q, y_q, acc_q;
	logic  run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (load) begin
			run_q <= 1'b1;
		end else if (run_q && y_q == '0) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (run_q && y_q != '0) begin
			if (y_q[0]) begin
				acc_q <= add_mod(acc_q, x_q, m);
			end
			x_q <= add_mod(x_q, x_q, m);
			y_q <= y_q >> 1;
		end
	end

	assign done = run_q && y_q == '0;
	assign prod = acc_q;
endmodule

// ===== rtl/core/m2pm_reduce.sv =====
module m2pm_reduce (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  m2pm_pkg::elem_t a,
	input  m2pm_pkg::elem_t m,
	output logic           done,
	output m2pm_pkg::elem_t rem
);
	import m2pm_pkg::*;

	elem_t            a_q;
	logic [ElemWidth:0] r_q;
	logic [CntWidth-1:0] cnt_q;
	logic             run_q;
	logic [ElemWidth:0] sh;

	assign sh = {r_q[ElemWidth-1:0], a_q[ElemWidth-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= CntWidth'(ElemWidth);
		end else if (run_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= a;
			r_q <= '0;
		end else if (run_q && cnt_q != '0) begin
			a_q <= a_q << 1;
			r_q <= (sh >= {1'b0, m}) ? sh - {1'b0, m} : sh;
		end
	end

	assign done = run_q && cnt_q == '0;
	assign rem  = r_q[ElemWidth-1:0];
endmodule
